// ===== hdl/pcbd_pkg.sv =====
// shared types and constants for the pulse-count backlight dimmer
`timescale 1ns / 1ps

package pcbd_pkg;

  // default number of chip levels, level count minus one is off
  localparam int PCBD_NUM_LEVELS = 16;

  // config register widths and reset values
  localparam int CFG_DATA_W   = 14;
  localparam int CFG_INDEX_W  = 2;
  localparam logic [6:0]  MASK_RESET     = 7'd127;
  localparam logic [7:0]  EN_WAIT_RESET  = 8'd40;
  localparam logic [13:0] OFF_WAIT_RESET = 14'd10000;
  localparam logic [7:0]  HALF_RESET     = 8'd1;

  // percent limit and reciprocal for divide by 100 (exact for dividends below 43690)
  localparam logic [6:0] PERCENT_MAX = 7'd100;
  localparam int DIV_SHIFT = 19;
  localparam int DIV_RECIP = 5243;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BATTERY_LIMIT_MASK = 2'd0,
    REG_ENABLE_WAIT_TICKS  = 2'd1,
    REG_OFF_WAIT_TICKS     = 2'd2,
    REG_PULSE_HALF_TICKS   = 2'd3
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_TICK  = 2'd0,
    ST_OK    = 2'd1,
    ST_BUSY  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [6:0]  battery_limit_mask;
    logic [7:0]  enable_wait_ticks;
    logic [13:0] off_wait_ticks;
    logic [7:0]  pulse_half_ticks;
  } cfg_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [6:0] brightness;
    logic       power_unblank;
    logic       fb_blank;
    logic       suspended;
    logic       suspend_resume;
    logic       battery_low;
    logic       lcd_on;
  } req_t;

  typedef struct packed {
    logic       pin;
    logic       busy_res;
    logic [3:0] level_now;
    logic [6:0] reported_brightness;
    status_t    request_status;
  } res_t;

endpackage

// ===== hdl/pcbd_cfg_regs.sv =====
// configuration register file of the dimmer
`timescale 1ns / 1ps

module pcbd_cfg_regs
  import pcbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_limit_mask <= MASK_RESET;
      cfg.enable_wait_ticks  <= EN_WAIT_RESET;
      cfg.off_wait_ticks     <= OFF_WAIT_RESET;
      cfg.pulse_half_ticks   <= HALF_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BATTERY_LIMIT_MASK: cfg.battery_limit_mask <= cfg_data[6:0];
        REG_ENABLE_WAIT_TICKS:  cfg.enable_wait_ticks  <= cfg_data[7:0];
        REG_OFF_WAIT_TICKS:     cfg.off_wait_ticks     <= cfg_data[13:0];
        REG_PULSE_HALF_TICKS:   cfg.pulse_half_ticks   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/pcbd_sequencer.sv =====
// level mapping, pin sequencer state and next-result logic
`timescale 1ns / 1ps

module pcbd_sequencer
  import pcbd_pkg::*;
#(
  parameter int NUM_LEVELS = PCBD_NUM_LEVELS
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t item,
  input  cfg_t cfg,
  output res_t result
);

  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam logic [LVL_W-1:0] LVL_OFF = LVL_W'(NUM_LEVELS - 1);
  localparam int MUL_W = 7 + $clog2((NUM_LEVELS - 1) * DIV_RECIP + 1);
  localparam logic [MUL_W-1:0] SCALE_MUL = MUL_W'((NUM_LEVELS - 1) * DIV_RECIP);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_OFFWAIT = 5'b00010,
    PH_ENWAIT  = 5'b00100,
    PH_LOW     = 5'b01000,
    PH_HIGH    = 5'b10000
  } phase_t;

  logic             init_done, init_done_next;
  logic [LVL_W-1:0] level_reg, level_reg_next;
  logic             pin_reg, pin_reg_next;
  phase_t           phase, phase_next;
  logic [13:0]      tick_count, tick_count_next;
  logic [LVL_W-1:0] pulses_left, pulses_left_next;
  logic [LVL_W-1:0] target_level, target_level_next;
  logic [6:0]       stored_brightness, stored_brightness_next;
  status_t          status;

  logic [6:0]       intensity;
  logic [6:0]       percent;
  logic [MUL_W-1:0] scaled_prod;
  logic [LVL_W-1:0] scaled;
  logic [LVL_W-1:0] new_level;
  logic [LVL_W-1:0] cur_level;
  logic [LVL_W:0]   diff;
  logic [13:0]      half_ticks;
  logic [13:0]      en_ticks;
  logic [13:0]      off_ticks;
  logic [LVL_W-1:0] pulses_dec;

  // flag gating and percent to level mapping
  always_comb begin
    intensity = item.brightness;
    if (!item.power_unblank) intensity = '0;
    if (item.fb_blank)       intensity = '0;
    if (item.suspended)      intensity = '0;
    if (item.suspend_resume) intensity = item.brightness;
    if (item.battery_low)    intensity = intensity & cfg.battery_limit_mask;
    percent     = item.lcd_on ? intensity : '0;
    scaled_prod = MUL_W'(percent) * SCALE_MUL;
    scaled      = LVL_W'(scaled_prod >> DIV_SHIFT);
    new_level   = LVL_OFF - scaled;
  end

  // zero wait registers act as one tick
  assign half_ticks = (cfg.pulse_half_ticks == '0) ? 14'd1 : 14'(cfg.pulse_half_ticks);
  assign en_ticks   = (cfg.enable_wait_ticks == '0) ? 14'd1 : 14'(cfg.enable_wait_ticks);
  assign off_ticks  = (cfg.off_wait_ticks == '0) ? 14'd1 : cfg.off_wait_ticks;

  assign cur_level  = init_done ? level_reg : LVL_OFF;
  assign pulses_dec = (pulses_left != '0) ? pulses_left - LVL_W'(1) : pulses_left;

  always_comb begin
    init_done_next         = init_done;
    level_reg_next         = level_reg;
    pin_reg_next           = pin_reg;
    phase_next             = phase;
    tick_count_next        = tick_count;
    pulses_left_next       = pulses_left;
    target_level_next      = target_level;
    stored_brightness_next = stored_brightness;
    status                 = ST_TICK;
    diff                   = {1'b0, new_level} - {1'b0, cur_level};
    if (new_level < cur_level) diff = diff + (LVL_W + 1)'(NUM_LEVELS);

    if (item.opcode == OP_REQUEST) begin
      if (phase != PH_IDLE) begin
        status = ST_BUSY;
      end else begin
        if (item.lcd_on) stored_brightness_next = intensity;
        if (percent > PERCENT_MAX) begin
          status = ST_RANGE;
        end else begin
          status = ST_OK;
          // first request powers the chip up at the off level
          if (!init_done) begin
            pin_reg_next   = 1'b1;
            level_reg_next = LVL_OFF;
            init_done_next = 1'b1;
          end
          if (new_level == LVL_OFF) begin
            pin_reg_next      = 1'b0;
            level_reg_next    = LVL_OFF;
            target_level_next = LVL_OFF;
            phase_next        = PH_OFFWAIT;
            tick_count_next   = off_ticks;
          end else if (cur_level != LVL_OFF && new_level == cur_level) begin
            // level unchanged, nothing to drive
          end else begin
            target_level_next = new_level;
            if (cur_level == LVL_OFF) begin
              pulses_left_next = new_level;
              pin_reg_next     = 1'b1;
              phase_next       = PH_ENWAIT;
              tick_count_next  = en_ticks;
            end else begin
              pulses_left_next = diff[LVL_W-1:0];
              pin_reg_next     = 1'b0;
              phase_next       = PH_LOW;
              tick_count_next  = half_ticks;
            end
          end
        end
      end
    end else if (phase != PH_IDLE) begin
      if (tick_count > 14'd1) begin
        tick_count_next = tick_count - 14'd1;
      end else begin
        tick_count_next = '0;
        unique case (phase)
          PH_OFFWAIT: phase_next = PH_IDLE;
          PH_ENWAIT: begin
            if (pulses_left != '0) begin
              pin_reg_next    = 1'b0;
              phase_next      = PH_LOW;
              tick_count_next = half_ticks;
            end else begin
              level_reg_next = target_level;
              phase_next     = PH_IDLE;
            end
          end
          PH_LOW: begin
            pin_reg_next    = 1'b1;
            phase_next      = PH_HIGH;
            tick_count_next = half_ticks;
          end
          PH_HIGH: begin
            pulses_left_next = pulses_dec;
            if (pulses_dec != '0) begin
              pin_reg_next    = 1'b0;
              phase_next      = PH_LOW;
              tick_count_next = half_ticks;
            end else begin
              level_reg_next = target_level;
              phase_next     = PH_IDLE;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_done         <= 1'b0;
      level_reg         <= LVL_OFF;
      pin_reg           <= 1'b0;
      phase             <= PH_IDLE;
      tick_count        <= '0;
      pulses_left       <= '0;
      target_level      <= LVL_OFF;
      stored_brightness <= '0;
    end else if (fire) begin
      init_done         <= init_done_next;
      level_reg         <= level_reg_next;
      pin_reg           <= pin_reg_next;
      phase             <= phase_next;
      tick_count        <= tick_count_next;
      pulses_left       <= pulses_left_next;
      target_level      <= target_level_next;
      stored_brightness <= stored_brightness_next;
    end
  end

  assign result.pin                 = pin_reg_next;
  assign result.busy_res            = (phase_next != PH_IDLE);
  assign result.level_now           = 4'(level_reg_next);
  assign result.reported_brightness = stored_brightness_next;
  assign result.request_status      = status;

`ifndef SYNTHESIS
  a_busy_drop_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && item.opcode == OP_REQUEST && phase != PH_IDLE) |=>
      ($stable(level_reg) && $stable(pin_reg) && $stable(phase) &&
       $stable(stored_brightness) && $stable(tick_count)))
    else $error("dropped request changed sequencer state");
  a_active_has_ticks: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (tick_count != '0))
    else $error("active phase with empty tick counter");
  a_pulse_pin_low: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LOW) |-> !pin_reg)
    else $error("pin high during low pulse half");
  a_pulse_pin_high: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HIGH || phase == PH_ENWAIT) |-> pin_reg)
    else $error("pin low during high pulse half or enable wait");
  a_off_wait_state: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_OFFWAIT) |-> (!pin_reg && level_reg == LVL_OFF))
    else $error("off wait without pin dropped at off level");
`endif

endmodule

// ===== hdl/pulse_count_backlight_dimmer.sv =====
// top level of the pulse-count backlight dimmer
`timescale 1ns / 1ps
// path: the item transfer loads the input register, then the held item loads the result
//   register once that register is free or drains
// throughput: one item per cycle while the result side does not stall
// reset: synchronous; config returns to defaults, the chip level reads off, pin low, idle

module pulse_count_backlight_dimmer
  import pcbd_pkg::*;
#(
  parameter int NUM_LEVELS = PCBD_NUM_LEVELS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   opcode,
  input  logic [6:0]             brightness,
  input  logic                   power_unblank,
  input  logic                   fb_blank,
  input  logic                   suspended,
  input  logic                   suspend_resume,
  input  logic                   battery_low,
  input  logic                   lcd_on,
  // result channel
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic                   pin,
  output logic                   busy_res,
  output logic [3:0]             level_now,
  output logic [6:0]             reported_brightness,
  output logic [1:0]             request_status
);

  cfg_t cfg;
  req_t item;
  logic item_valid;
  res_t result_next;
  res_t result;
  logic advance;

  pcbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // held item moves into the result register when that register is free or drains
  assign advance   = item_valid && (!res_valid || !res_stall);
  assign req_stall = item_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      item.opcode         <= opcode_t'(opcode);
      item.brightness     <= brightness;
      item.power_unblank  <= power_unblank;
      item.fb_blank       <= fb_blank;
      item.suspended      <= suspended;
      item.suspend_resume <= suspend_resume;
      item.battery_low    <= battery_low;
      item.lcd_on         <= lcd_on;
    end
  end

  // state advances only on the transfer into the result register
  pcbd_sequencer #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign pin                 = result.pin;
  assign busy_res            = result.busy_res;
  assign level_now           = result.level_now;
  assign reported_brightness = result.reported_brightness;
  assign request_status      = result.request_status;

endmodule

// ===== tb/tb_pulse_count_backlight_dimmer.sv =====
// self-checking testbench for the pulse-count backlight dimmer
`timescale 1ns / 1ps

module tb_pulse_count_backlight_dimmer
  import pcbd_pkg::*;
();

  // sequencer phases of the dimmer, tracked by the predictor
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_OFFWAIT,
    SEQ_ENWAIT,
    SEQ_LOW,
    SEQ_HIGH
  } seq_t;

  localparam int LVL_OFF = PCBD_NUM_LEVELS - 1;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   req_valid;
  logic                   req_stall;
  logic                   opcode;
  logic [6:0]             brightness;
  logic                   power_unblank;
  logic                   fb_blank;
  logic                   suspended;
  logic                   suspend_resume;
  logic                   battery_low;
  logic                   lcd_on;
  logic                   res_valid;
  logic                   res_stall;
  logic                   pin;
  logic                   busy_res;
  logic [3:0]             level_now;
  logic [6:0]             reported_brightness;
  logic [1:0]             request_status;

  pulse_count_backlight_dimmer uut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .req_valid           (req_valid),
    .req_stall           (req_stall),
    .opcode              (opcode),
    .brightness          (brightness),
    .power_unblank       (power_unblank),
    .fb_blank            (fb_blank),
    .suspended           (suspended),
    .suspend_resume      (suspend_resume),
    .battery_low         (battery_low),
    .lcd_on              (lcd_on),
    .res_valid           (res_valid),
    .res_stall           (res_stall),
    .pin                 (pin),
    .busy_res            (busy_res),
    .level_now           (level_now),
    .reported_brightness (reported_brightness),
    .request_status      (request_status)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // predicted dimmer state: config copy and sequencer
  logic [6:0]  m_mask;
  logic [7:0]  m_enw;
  logic [13:0] m_offw;
  logic [7:0]  m_half;
  bit          m_init;
  int          m_level;
  int          m_target;
  int          m_pulses;
  int          m_ticks;
  bit          m_pin;
  seq_t        m_seq;
  logic [6:0]  m_stored;

  // predicted outputs waiting for their result transfer
  res_t pending_outputs[$];

  // directed stimulus table
  req_t dir_rq[$];
  bit   dir_typed[$];
  res_t dir_ex[$];

  // expectation typed into the table for the item currently offered
  bit   row_typed;
  res_t row_exp;

  int errors;
  int n_checked;
  bit calm;       // no idling on either side while set
  bit held_long;  // the long receiver hold-off has been done

  // a wait register holding zero still lasts one tick
  function automatic int ticks_of(int v);
    return (v == 0) ? 1 : v;
  endfunction

  // pin low for the first half of a pulse
  task automatic start_low_half;
    m_pin   = 1'b0;
    m_seq   = SEQ_LOW;
    m_ticks = ticks_of(m_half);
  endtask

  // the pulsed level only becomes the committed level here
  task automatic end_sequence;
    m_level = m_target;
    m_seq   = SEQ_IDLE;
  endtask

  task automatic drive_to(int lvl);
    int pulses;
    pulses = lvl;
    // very first drive powers the chip up at the off level
    if (!m_init) begin
      m_pin   = 1'b1;
      m_level = LVL_OFF;
      m_init  = 1'b1;
    end
    // off level: drop the pin and commit at once
    if (lvl == LVL_OFF) begin
      m_pin    = 1'b0;
      m_level  = LVL_OFF;
      m_target = LVL_OFF;
      m_seq    = SEQ_OFFWAIT;
      m_ticks  = ticks_of(m_offw);
      return;
    end
    // chip on: pulse count is the level step, wrapped around the level count
    if (m_level != LVL_OFF) begin
      if (lvl < m_level) pulses = lvl + PCBD_NUM_LEVELS - m_level;
      else if (lvl > m_level) pulses = lvl - m_level;
      else return;
    end
    m_target = lvl;
    m_pulses = pulses;
    if (m_level == LVL_OFF) begin
      m_pin   = 1'b1;
      m_seq   = SEQ_ENWAIT;
      m_ticks = ticks_of(m_enw);
    end else begin
      start_low_half();
    end
  endtask

  // advance the predicted dimmer by one accepted item and form its result
  task automatic predict_dimmer(input req_t rq, output res_t r);
    logic [6:0] inten;
    int         pct;
    status_t    st;
    st = ST_TICK;
    if (rq.opcode == OP_TICK) begin
      if (m_seq != SEQ_IDLE) begin
        if (m_ticks > 1) begin
          m_ticks--;
        end else begin
          m_ticks = 0;
          case (m_seq)
            SEQ_OFFWAIT: m_seq = SEQ_IDLE;
            SEQ_ENWAIT: begin
              if (m_pulses > 0) start_low_half();
              else end_sequence();
            end
            SEQ_LOW: begin
              m_pin   = 1'b1;
              m_seq   = SEQ_HIGH;
              m_ticks = ticks_of(m_half);
            end
            SEQ_HIGH: begin
              if (m_pulses > 0) m_pulses--;
              if (m_pulses > 0) start_low_half();
              else end_sequence();
            end
            default: m_seq = SEQ_IDLE;
          endcase
        end
      end
    end else if (m_seq != SEQ_IDLE) begin
      st = ST_BUSY;
    end else begin
      inten = rq.brightness;
      if (!rq.power_unblank) inten = '0;
      if (rq.fb_blank) inten = '0;
      if (rq.suspended) inten = '0;
      if (rq.suspend_resume) inten = rq.brightness;
      if (rq.battery_low) inten = inten & m_mask;
      if (rq.lcd_on) begin
        pct      = inten;
        m_stored = inten;
      end else begin
        pct = 0;
      end
      if (pct > PERCENT_MAX) begin
        st = ST_RANGE;
      end else begin
        drive_to(LVL_OFF - LVL_OFF * pct / int'(PERCENT_MAX));
        st = ST_OK;
      end
    end
    r.pin                 = m_pin;
    r.busy_res            = (m_seq != SEQ_IDLE);
    r.level_now           = m_level[3:0];
    r.reported_brightness = m_stored;
    r.request_status      = st;
  endtask

  task automatic cmp_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // predict on every input transfer, check on every result transfer
  always @(posedge clk) begin : scoreboard
    req_t seen;
    res_t guess;
    res_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        seen.opcode         = opcode_t'(opcode);
        seen.brightness     = brightness;
        seen.power_unblank  = power_unblank;
        seen.fb_blank       = fb_blank;
        seen.suspended      = suspended;
        seen.suspend_resume = suspend_resume;
        seen.battery_low    = battery_low;
        seen.lcd_on         = lcd_on;
        predict_dimmer(seen, guess);
        // typed table rows take precedence, the predictor still tracks state
        pending_outputs.push_back(row_typed ? row_exp : guess);
      end
      if (res_valid && !res_stall) begin
        n_checked++;
        if (pending_outputs.size() == 0) begin
          $display("%0t ns: result with nothing pending, expected none, got pin %0d level %0d",
                   $time, pin, level_now);
          errors++;
        end else begin
          want = pending_outputs.pop_front();
          cmp_field("pin", want.pin, pin);
          cmp_field("busy_res", want.busy_res, busy_res);
          cmp_field("level_now", want.level_now, level_now);
          cmp_field("reported_brightness", want.reported_brightness, reported_brightness);
          cmp_field("request_status", int'(want.request_status), request_status);
        end
      end
    end
  end

  // result side stall: mostly short runs, a few long, one long hold-off
  initial begin : result_backpressure
    int r;
    forever begin
      if (calm) begin
        res_stall = 1'b0;
        @(negedge clk);
      end else if (!held_long && n_checked >= 150) begin
        // hold results back long enough that the block fills and stalls its input
        held_long = 1'b1;
        res_stall = 1'b1;
        repeat (120) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        res_stall = (r >= 60);
        if (r < 60) repeat ($urandom_range(1, 8)) @(negedge clk);
        else if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
        else repeat ($urandom_range(10, 30)) @(negedge clk);
      end
    end
  end

  // idle cycles before an input transfer
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic put_payload(req_t rq);
    opcode         = rq.opcode;
    brightness     = rq.brightness;
    power_unblank  = rq.power_unblank;
    fb_blank       = rq.fb_blank;
    suspended      = rq.suspended;
    suspend_resume = rq.suspend_resume;
    battery_low    = rq.battery_low;
    lcd_on         = rq.lcd_on;
  endtask

  // offer one item from a falling edge, return at the falling edge after its transfer
  task automatic offer(req_t rq, bit typed, res_t ex);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    put_payload(rq);
    row_typed = typed;
    row_exp   = ex;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted result has been seen
  task automatic settle;
    req_valid = 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      REG_BATTERY_LIMIT_MASK: m_mask = val[6:0];
      REG_ENABLE_WAIT_TICKS:  m_enw  = val[7:0];
      REG_OFF_WAIT_TICKS:     m_offw = val[13:0];
      REG_PULSE_HALF_TICKS:   m_half = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ticks carry random junk in the ignored fields
  function automatic req_t next_item(bit tick_only);
    req_t rq;
    int   r;
    rq = req_t'($urandom);
    rq.opcode = OP_TICK;
    r = $urandom_range(0, 99);
    // mostly ticks while a sequence runs, mostly requests while idle
    if (!tick_only && ((m_seq != SEQ_IDLE) ? (r < 15) : (r < 75))) begin
      rq.opcode = OP_REQUEST;
      r = $urandom_range(0, 99);
      if (r < 70) rq.brightness = 7'($urandom_range(0, 100));
      else if (r < 85) rq.brightness = 7'($urandom_range(101, 127));
      else rq.brightness = $urandom_range(0, 1) ? 7'd100 : 7'd0;
      rq.power_unblank  = ($urandom_range(0, 99) < 85);
      rq.fb_blank       = ($urandom_range(0, 99) < 10);
      rq.suspended      = ($urandom_range(0, 99) < 10);
      rq.suspend_resume = ($urandom_range(0, 99) < 15);
      rq.battery_low    = ($urandom_range(0, 99) < 25);
      rq.lcd_on         = ($urandom_range(0, 99) < 85);
    end
    return rq;
  endfunction

  // tick until the running sequence has ended, then drain the results
  task automatic run_out;
    while (m_seq != SEQ_IDLE) offer(next_item(1'b1), 1'b0, '0);
    settle();
  endtask

  task automatic run_phase(logic [13:0] mask_v, logic [13:0] en_v, logic [13:0] off_v,
                           logic [13:0] half_v, int n, bit quiet);
    write_reg(REG_BATTERY_LIMIT_MASK, mask_v);
    write_reg(REG_ENABLE_WAIT_TICKS, en_v);
    write_reg(REG_OFF_WAIT_TICKS, off_v);
    write_reg(REG_PULSE_HALF_TICKS, half_v);
    calm = quiet;
    for (int k = 0; k < n; k++) begin
      offer(next_item(1'b0), 1'b0, '0);
      // sender pause until the block has emptied
      if (k == n / 2) settle();
    end
    run_out();
    calm = 1'b0;
  endtask

  // table rows; flags are {unblank, blank, suspended, resume, battery_low, lcd_on}
  task automatic add_checked_step(opcode_t op, logic [6:0] br, logic [5:0] fl,
                                  logic e_pin, logic e_busy, logic [3:0] e_lvl,
                                  logic [6:0] e_rep, status_t e_st, bit typed = 1'b1);
    req_t rq;
    res_t ex;
    rq.opcode     = op;
    rq.brightness = br;
    {rq.power_unblank, rq.fb_blank, rq.suspended,
     rq.suspend_resume, rq.battery_low, rq.lcd_on} = fl;
    ex.pin                 = e_pin;
    ex.busy_res            = e_busy;
    ex.level_now           = e_lvl;
    ex.reported_brightness = e_rep;
    ex.request_status      = e_st;
    dir_rq.push_back(rq);
    dir_typed.push_back(typed);
    dir_ex.push_back(ex);
  endtask

  task automatic add_step(opcode_t op, logic [6:0] br, logic [5:0] fl, int reps = 1);
    repeat (reps) add_checked_step(op, br, fl, 1'b0, 1'b0, 4'd0, 7'd0, ST_TICK, 1'b0);
  endtask

  initial begin : stimulus
    // every input known from time zero
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_BATTERY_LIMIT_MASK;
    cfg_data  = '0;
    req_valid = 1'b0;
    put_payload('0);
    row_typed = 1'b0;
    row_exp   = '0;
    errors    = 0;
    n_checked = 0;
    calm      = 1'b0;
    held_long = 1'b0;

    // predictor starts from the reset state
    m_mask   = MASK_RESET;
    m_enw    = EN_WAIT_RESET;
    m_offw   = OFF_WAIT_RESET;
    m_half   = HALF_RESET;
    m_init   = 1'b0;
    m_level  = LVL_OFF;
    m_target = LVL_OFF;
    m_pulses = 0;
    m_ticks  = 0;
    m_pin    = 1'b0;
    m_seq    = SEQ_IDLE;
    m_stored = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // short waits keep the directed part compact
    write_reg(REG_BATTERY_LIMIT_MASK, 14'h000F);
    write_reg(REG_ENABLE_WAIT_TICKS, 14'd2);
    write_reg(REG_OFF_WAIT_TICKS, 14'd3);
    write_reg(REG_PULSE_HALF_TICKS, 14'd1);

    // reset state seen through an idle tick
    add_checked_step(OP_TICK, 7'd0, 6'b000000, 1'b0, 1'b0, 4'd15, 7'd0, ST_TICK);
    // top of the 7-bit brightness range and just over 100: rejected but still stored
    add_checked_step(OP_REQUEST, 7'd127, 6'b100001, 1'b0, 1'b0, 4'd15, 7'd127, ST_RANGE);
    add_checked_step(OP_REQUEST, 7'd101, 6'b100001, 1'b0, 1'b0, 4'd15, 7'd101, ST_RANGE);
    // lcd disabled on the first request: init then straight to off, nothing stored
    add_checked_step(OP_REQUEST, 7'd120, 6'b100000, 1'b0, 1'b1, 4'd15, 7'd101, ST_OK);
    // request during the off wait is dropped
    add_checked_step(OP_REQUEST, 7'd50, 6'b100001, 1'b0, 1'b1, 4'd15, 7'd101, ST_BUSY);
    add_step(OP_TICK, 7'd0, 6'b000000, 3);
    // chip off, target full scale: enable wait, then zero pulses
    add_step(OP_REQUEST, 7'd100, 6'b100001);
    add_step(OP_TICK, 7'd0, 6'b000000, 2);
    // same level again while on
    add_step(OP_REQUEST, 7'd100, 6'b100001);
    // one pulse step up to level 1
    add_step(OP_REQUEST, 7'd95, 6'b100001);
    add_step(OP_TICK, 7'd0, 6'b000000, 2);
    // suspended forces off
    add_step(OP_REQUEST, 7'd100, 6'b101001);
    add_step(OP_TICK, 7'd0, 6'b000000, 3);
    // resume beats blank and power-down, battery mask then cuts the percent
    add_step(OP_REQUEST, 7'd127, 6'b010111);
    add_step(OP_REQUEST, 7'd0, 6'b100001);

    foreach (dir_rq[i]) offer(dir_rq[i], dir_typed[i], dir_ex[i]);
    run_out();

    // random phases over several register settings
    run_phase(14'd127, 14'd4, 14'd6, 14'd1, 450, 1'b0);
    // bits above each register width are dropped; no idling here
    run_phase(14'h3FA5, 14'h3F01, 14'd1, 14'h3F02, 250, 1'b1);
    // zero waits behave as one tick
    run_phase(14'd0, 14'd0, 14'd0, 14'd0, 300, 1'b0);
    // longer waits, few items
    run_phase(14'd127, 14'd40, 14'd200, 14'd8, 30, 1'b0);
    run_phase(14'($urandom_range(0, 127)), 14'($urandom_range(1, 6)),
              14'($urandom_range(1, 12)), 14'($urandom_range(1, 3)), 600, 1'b0);

    repeat (20) @(negedge clk);
    if (pending_outputs.size() != 0) begin
      $display("%0t ns: results left over, expected 0, got %0d", $time,
               pending_outputs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pcbd_pkg.sv
hdl/pcbd_cfg_regs.sv
hdl/pcbd_sequencer.sv
hdl/pulse_count_backlight_dimmer.sv
tb/tb_pulse_count_backlight_dimmer.sv
